/* rtl/lcgn_pkg.sv */
// Shared types and constants for the LCG uniform noise generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lcgn_pkg;

    localparam int STATE_W   = 64;
    localparam int AMP_W     = 32;
    localparam int WSEL_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int SAMPLE_W  = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam int MAX_BURST_DEF = 64;

    localparam logic [STATE_W-1:0] MULT_RST = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] INC_RST  = 64'd1442695040888963407;
    localparam logic [AMP_W-1:0]   AMP_RST  = 32'd65536;
    localparam logic [WSEL_W-1:0]  WSEL_RST = 2'd0;
    localparam logic               SGN_RST  = 1'b1;

    localparam logic CMD_GEN  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_32 = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT = 3'd0,
        CFG_INC  = 3'd1,
        CFG_AMP  = 3'd2,
        CFG_WSEL = 3'd3,
        CFG_SGN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [STATE_W-1:0] mult;
        logic [STATE_W-1:0] inc;
        logic [AMP_W-1:0]   amp;
        logic [WSEL_W-1:0]  wsel;
        logic               sgn;
    } t_cfg;

endpackage

/* rtl/lcgn_ifs.sv */
// Handshake interfaces: command words in, sample words out, config writes.
// Depends on lcgn_pkg.
`timescale 1ns / 1ps

interface lcgn_cmd_if;
    import lcgn_pkg::*;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [STATE_W-1:0] seed_value;
    logic [COUNT_W-1:0] sample_count;

    modport source (output valid, cmd, seed_value, sample_count, input ready);
    modport sink   (input valid, cmd, seed_value, sample_count, output ready);
endinterface

interface lcgn_smp_if;
    import lcgn_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STATE_W-1:0]         state_after;
    logic                       last;

    modport source (output valid, sample, state_after, last, input ready);
    modport sink   (input valid, sample, state_after, last, output ready);
endinterface

interface lcgn_cfg_if;
    import lcgn_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/lcgn_cfg_regs.sv */
// Configuration register file: multiplier, increment, amplitude, width, mode.
// Depends on lcgn_pkg and lcgn_cfg_if.
`timescale 1ns / 1ps

module lcgn_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcgn_cfg_if.sink      i_cfg_ch,
    output lcgn_pkg::t_cfg o_cfg
);
    import lcgn_pkg::*;

    t_cfg r_cfg;

    assign i_cfg_ch.ready = 1'b1;
    assign o_cfg          = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mult <= MULT_RST;
            r_cfg.inc  <= INC_RST;
            r_cfg.amp  <= AMP_RST;
            r_cfg.wsel <= WSEL_RST;
            r_cfg.sgn  <= SGN_RST;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                CFG_MULT: r_cfg.mult <= i_cfg_ch.data;
                CFG_INC:  r_cfg.inc  <= i_cfg_ch.data;
                CFG_AMP:  r_cfg.amp  <= i_cfg_ch.data[AMP_W-1:0];
                CFG_WSEL: r_cfg.wsel <= i_cfg_ch.data[WSEL_W-1:0];
                CFG_SGN:  r_cfg.sgn  <= i_cfg_ch.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/lcgn_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// No package dependencies.
`timescale 1ns / 1ps

module lcgn_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {32'd0, i_a} * {32'd0, i_b};
        end
    end

endmodule

/* rtl/lcg_uniform_noise_generator_unit.sv */
// Top level of the LCG uniform noise generator: sequencer and datapath.
// Depends on lcgn_pkg, lcgn_ifs, lcgn_cfg_regs, lcgn_mul.
//
//  channel    dir  word                                     accepted when
//  i_cmd_ch   in   cmd, seed_value[63:0], sample_count[6:0]  valid & ready
//  o_smp_ch   out  sample[32:0], state_after[63:0], last     valid & ready
//  i_cfg_ch   in   index[2:0], data[63:0]                    valid & ready (always ready)
//
// Each sample runs through LCG0-LCG3, FRAC, SCL0, SCL1 and SAT and uses one shared
// 32x32 multiplier: three partial products for the 64-bit state update, two for
// amplitude scaling. Each sample waits in SAT for the output register; a load goes
// through LOAD. Command ready is high only in the idle state.
// The output register holds one word, so the next sample is computed while
// the previous waits; a stalled sink holds the sequencer at the round step.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module lcg_uniform_noise_generator_unit #(
    parameter int MAX_BURST = lcgn_pkg::MAX_BURST_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcgn_cmd_if.sink  i_cmd_ch,
    lcgn_smp_if.source o_smp_ch,
    lcgn_cfg_if.sink  i_cfg_ch
);
    import lcgn_pkg::*;

    localparam int LeftW = $clog2(MAX_BURST + 1);
    localparam int MagW  = 17;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_LOAD = 10'b00_0000_0010,
        ST_LCG0 = 10'b00_0000_0100,
        ST_LCG1 = 10'b00_0000_1000,
        ST_LCG2 = 10'b00_0001_0000,
        ST_LCG3 = 10'b00_0010_0000,
        ST_FRAC = 10'b00_0100_0000,
        ST_SCL0 = 10'b00_1000_0000,
        ST_SCL1 = 10'b01_0000_0000,
        ST_SAT  = 10'b10_0000_0000
    } t_st;

    t_cfg w_cfg;

    t_st                r_st;
    logic [STATE_W-1:0] r_state;
    logic [LeftW-1:0]   r_left;
    logic [STATE_W-1:0] r_acc;
    logic [STATE_W-1:0] r_fmag;
    logic [AMP_W-1:0]   r_amag;
    logic               r_neg;

    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [STATE_W-1:0]         r_state_after;
    logic                       r_last;

    logic        w_mul_en;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic        w_slot_free;
    logic        w_out_set;
    logic        w_cmd_acc;
    logic [COUNT_W-1:0] w_count;
    logic [LeftW-1:0]   w_count_clamped;

    lcgn_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_ch(i_cfg_ch),
        .o_cfg   (w_cfg)
    );

    lcgn_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_prod(w_prod)
    );

    // round half away from zero, then clamp to the selected width
    function automatic logic [SAMPLE_W-1:0] f_round_sat(
        input logic [STATE_W-1:0] mid,
        input logic               sgn,
        input logic               neg_sign,
        input logic [WSEL_W-1:0]  wsel
    );
        logic [STATE_W:0]     sum;
        logic [STATE_W:0]     shifted;
        logic [MagW-1:0]      mag;
        logic signed [MagW:0] v;
        logic signed [33:0]   v_ext;
        logic signed [33:0]   hi;
        logic signed [33:0]   lo;
        logic signed [33:0]   res;
        sum     = {1'b0, mid} + (sgn ? (65'd1 << 46) : (65'd1 << 47));
        shifted = sgn ? (sum >> 47) : (sum >> 48);
        mag     = shifted[MagW-1:0];
        v       = (neg_sign && (mag != '0)) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        v_ext   = 34'(v);
        case (wsel)
            WSEL_8: begin
                hi = sgn ? 34'sd127 : 34'sd255;
                lo = sgn ? -34'sd128 : 34'sd0;
            end
            WSEL_16: begin
                hi = sgn ? 34'sd32767 : 34'sd65535;
                lo = sgn ? -34'sd32768 : 34'sd0;
            end
            default: begin
                hi = sgn ? 34'sd2147483647 : 34'sd4294967295;
                lo = sgn ? -34'sd2147483648 : 34'sd0;
            end
        endcase
        if (v_ext > hi) begin
            res = hi;
        end else if (v_ext < lo) begin
            res = lo;
        end else begin
            res = v_ext;
        end
        return res[SAMPLE_W-1:0];
    endfunction

    assign w_slot_free     = !r_ovalid || o_smp_ch.ready;
    assign w_out_set       = w_slot_free && ((r_st == ST_LOAD) || (r_st == ST_SAT));
    assign i_cmd_ch.ready  = (r_st == ST_IDLE);
    assign w_cmd_acc       = i_cmd_ch.valid && i_cmd_ch.ready;
    assign w_count         = i_cmd_ch.sample_count;
    assign w_count_clamped = (w_count > COUNT_W'(MAX_BURST)) ? LeftW'(MAX_BURST)
                                                             : LeftW'(w_count);

    assign o_smp_ch.valid       = r_ovalid;
    assign o_smp_ch.sample      = r_sample;
    assign o_smp_ch.state_after = r_state_after;
    assign o_smp_ch.last        = r_last;

    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_st)
            ST_LCG0: begin
                w_mul_a = r_state[31:0];
                w_mul_b = w_cfg.mult[31:0];
            end
            ST_LCG1: begin
                w_mul_a = r_state[31:0];
                w_mul_b = w_cfg.mult[63:32];
            end
            ST_LCG2: begin
                w_mul_a = r_state[63:32];
                w_mul_b = w_cfg.mult[31:0];
            end
            ST_SCL0: begin
                w_mul_a = r_amag;
                w_mul_b = r_fmag[31:0];
            end
            ST_SCL1: begin
                w_mul_a = r_amag;
                w_mul_b = r_fmag[63:32];
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_state  <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_smp_ch.ready && !w_out_set) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (w_cmd_acc) begin
                        if (i_cmd_ch.cmd == CMD_LOAD) begin
                            r_state <= i_cmd_ch.seed_value;
                            r_left  <= '0;
                            r_st    <= ST_LOAD;
                        end else if (w_count_clamped != '0) begin
                            r_left <= w_count_clamped;
                            r_st   <= ST_LCG0;
                        end
                    end
                end
                ST_LOAD: begin
                    if (w_slot_free) begin
                        r_ovalid      <= 1'b1;
                        r_sample      <= '0;
                        r_state_after <= r_state;
                        r_last        <= 1'b1;
                        r_st          <= ST_IDLE;
                    end
                end
                ST_LCG0: begin
                    r_st <= ST_LCG1;
                end
                ST_LCG1: begin
                    r_acc <= w_prod + w_cfg.inc;
                    r_st  <= ST_LCG2;
                end
                ST_LCG2: begin
                    r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
                    r_st         <= ST_LCG3;
                end
                ST_LCG3: begin
                    r_state <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                    r_left  <= r_left - LeftW'(1);
                    r_st    <= ST_FRAC;
                end
                ST_FRAC: begin
                    if (!w_cfg.sgn) begin
                        r_fmag <= r_state;
                    end else if (r_state[63]) begin
                        r_fmag <= {1'b0, r_state[62:0]};
                    end else begin
                        r_fmag <= {1'b1, 63'd0} - r_state;
                    end
                    r_amag <= w_cfg.amp[AMP_W-1] ? (AMP_W'(0) - w_cfg.amp) : w_cfg.amp;
                    r_neg  <= w_cfg.amp[AMP_W-1] ^ (w_cfg.sgn && !r_state[63]);
                    r_st   <= ST_SCL0;
                end
                ST_SCL0: begin
                    r_st <= ST_SCL1;
                end
                ST_SCL1: begin
                    r_acc <= {32'd0, w_prod[63:32]};
                    r_st  <= ST_SAT;
                end
                ST_SAT: begin
                    if (w_slot_free) begin
                        r_ovalid      <= 1'b1;
                        r_sample      <= f_round_sat(r_acc + w_prod, w_cfg.sgn, r_neg,
                                                     w_cfg.wsel);
                        r_state_after <= r_state;
                        r_last        <= (r_left == '0);
                        r_st          <= (r_left == '0) ? ST_IDLE : ST_LCG0;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
